// File: src/sha_pkg.sv
`default_nettype none

package sha_pkg;

    // Control word from the sequencer to the round unit
    typedef struct packed {
        logic       shift;      // shift data_byte into the block window
        logic [7:0] data_byte;
        logic       load;       // copy hash words into working variables
        logic       round;      // run one compression round
        logic       fold;       // add working variables into hash words
        logic       init;       // reload initial hash values
        logic [5:0] round_idx;
    } t_core_ctl;

    // Hash words, word 0 in the top slot of the digest
    typedef logic [7:0][31:0] t_hash_words;

    localparam logic [31:0] K_ROUND [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

endpackage

`default_nettype wire

// File: src/sha256_stream_hasher.sv
`default_nettype none
// SHA-256 over a byte stream, one optional byte per input word.
// After a word without end mark is accepted, ready returns once it is stored; the 64th byte of
// a block first runs a compression (load, 64 rounds on the shared round unit, fold).
// An end mark shifts in the pad bytes (up to 64) and then the length bytes, running
// one or two compressions, then four digest words, one per cycle while ready.
// Synchronous active-low reset restores initial hash values, zero fill and zero length.

module sha256_stream_hasher (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_msg_byte,
    input  wire logic        i_has_byte,
    input  wire logic        i_is_last,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [63:0]      o_digest_part,
    output logic             o_part_last
);
    import sha_pkg::*;

    localparam logic [5:0] FILL_MAX   = 6'd63;
    localparam logic [5:0] LEN_START  = 6'd56;
    localparam logic [5:0] ROUND_LAST = 6'd63;
    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [1:0] PART_LAST  = 2'd3;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_BYTE   = 9'b000000010,
        S_PAD80  = 9'b000000100,
        S_PADZ   = 9'b000001000,
        S_PADLEN = 9'b000010000,
        S_LOAD   = 9'b000100000,
        S_ROUND  = 9'b001000000,
        S_FOLD   = 9'b010000000,
        S_OUT    = 9'b100000000
    } t_state;

    t_state      r_state, n_state;
    t_state      r_ret, n_ret;
    logic        r_final, n_final;
    logic [5:0]  r_fill, n_fill;
    logic [63:0] r_bits, n_bits;
    logic [5:0]  r_round, n_round;
    logic [1:0]  r_part, n_part;
    logic [7:0]  r_byte, n_byte;
    logic        r_has, n_has;
    logic        r_last, n_last;
    t_core_ctl   ctl;
    t_hash_words hash;

    sha_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .o_hash  (hash)
    );

    // Sequencer
    always_comb begin
        n_state       = r_state;
        n_ret         = r_ret;
        n_final       = r_final;
        n_fill        = r_fill;
        n_bits        = r_bits;
        n_round       = r_round;
        n_part        = r_part;
        n_byte        = r_byte;
        n_has         = r_has;
        n_last        = r_last;
        ctl           = '0;
        ctl.round_idx = r_round;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_byte  = i_msg_byte;
                    n_has   = i_has_byte;
                    n_last  = i_is_last;
                    n_state = S_BYTE;
                end
            end
            S_BYTE: begin
                n_state = r_last ? S_PAD80 : S_IDLE;
                if (r_has) begin
                    ctl.shift     = 1'b1;
                    ctl.data_byte = r_byte;
                    n_fill        = r_fill + 6'd1;
                    n_bits        = r_bits + 64'd8;
                    if (r_fill == FILL_MAX) begin
                        n_ret   = r_last ? S_PAD80 : S_IDLE;
                        n_final = 1'b0;
                        n_state = S_LOAD;
                    end
                end
            end
            S_PAD80: begin
                ctl.shift     = 1'b1;
                ctl.data_byte = PAD_BYTE;
                n_fill        = r_fill + 6'd1;
                n_ret         = S_PADZ;
                n_final       = 1'b0;
                n_state       = (r_fill == FILL_MAX) ? S_LOAD : S_PADZ;
            end
            S_PADZ: begin
                if (r_fill == LEN_START) begin
                    n_state = S_PADLEN;
                end else begin
                    ctl.shift = 1'b1;
                    n_fill    = r_fill + 6'd1;
                    n_ret     = S_PADZ;
                    n_final   = 1'b0;
                    if (r_fill == FILL_MAX) begin
                        n_state = S_LOAD;
                    end
                end
            end
            S_PADLEN: begin
                // shift out the length, most significant byte first
                ctl.shift     = 1'b1;
                ctl.data_byte = r_bits[63:56];
                n_bits        = {r_bits[55:0], 8'h00};
                n_fill        = r_fill + 6'd1;
                if (r_fill == FILL_MAX) begin
                    n_final = 1'b1;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                ctl.load = 1'b1;
                n_round  = '0;
                n_state  = S_ROUND;
            end
            S_ROUND: begin
                ctl.round = 1'b1;
                n_round   = r_round + 6'd1;
                if (r_round == ROUND_LAST) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                ctl.fold = 1'b1;
                if (r_final) begin
                    n_part  = '0;
                    n_state = S_OUT;
                end else begin
                    n_state = r_ret;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    if (r_part == PART_LAST) begin
                        ctl.init = 1'b1;
                        n_fill   = '0;
                        n_bits   = '0;
                        n_final  = 1'b0;
                        n_state  = S_IDLE;
                    end else begin
                        n_part = r_part + 2'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_final <= 1'b0;
            r_fill  <= '0;
            r_bits  <= '0;
            r_round <= '0;
            r_part  <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_final <= n_final;
            r_fill  <= n_fill;
            r_bits  <= n_bits;
            r_round <= n_round;
            r_part  <= n_part;
        end
    end

    // Hold the accepted word
    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_has  <= n_has;
        r_last <= n_last;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_part_last = (r_part == PART_LAST);

    // Select the digest word, hash word pairs in order
    always_comb begin
        case (r_part)
            2'd0:    o_digest_part = {hash[0], hash[1]};
            2'd1:    o_digest_part = {hash[2], hash[3]};
            2'd2:    o_digest_part = {hash[4], hash[5]};
            default: o_digest_part = {hash[6], hash[7]};
        endcase
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while digest pending");

    a_rounds_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND && r_round == ROUND_LAST) |=> (r_state == S_FOLD))
        else $error("round count did not end compression");

    a_out_after_fold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_FOLD && $past(r_final)))
        else $error("digest shown without final compression");

    a_len_at_56: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PADLEN && $past(r_state) == S_PADZ) |-> (r_fill == LEN_START))
        else $error("length field started at wrong fill");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_part_last)
            |=> (o_in_ready && r_fill == '0 && r_bits == '0))
        else $error("message state not cleared after digest");

endmodule

`default_nettype wire

// File: src/sha_core.sv
`default_nettype none

module sha_core (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire sha_pkg::t_core_ctl   i_ctl,
    output sha_pkg::t_hash_words      o_hash
);
    import sha_pkg::*;

    // Block window: word 0 is the oldest word, also the schedule word of the round
    logic [31:0] r_w [16];
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] n_sched;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] maj;

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

    // Round datapath and schedule expansion
    always_comb begin
        n_sched = r_w[0] + ssig0(r_w[1]) + r_w[9] + ssig1(r_w[14]);
        ch      = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        maj     = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1      = r_v[7] + bsig1(r_v[4]) + ch + K_ROUND[i_ctl.round_idx] + r_w[0];
        t2      = bsig0(r_v[0]) + maj;
    end

    // Shift bytes in, or slide the schedule window during rounds
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= {r_w[i][23:0], r_w[i+1][31:24]};
            end
            r_w[15] <= {r_w[15][23:0], i_ctl.data_byte};
        end else if (i_ctl.round) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= n_sched;
        end
    end

    // Load working variables, then rotate them one round per cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_h[i];
            end
        end else if (i_ctl.round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    // Hash words: reload on reset or new message, accumulate after a block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.init) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= H_INIT[i];
            end
        end else if (i_ctl.fold) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= r_h[i] + r_v[i];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            o_hash[i] = r_h[i];
        end
    end

endmodule

`default_nettype wire

// File: tb/sha256_digest_checker.sv
`timescale 1ns / 1ps

module sha256_digest_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [7:0]  i_msg_byte,
    input  wire logic        i_has_byte,
    input  wire logic        i_is_last,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [63:0] i_digest_part,
    input  wire logic        i_part_last,
    output int               o_fail_count,
    output int               o_pending
);
    import sha_pkg::*;

    typedef struct packed {
        logic [63:0] part;
        logic        last;
    } t_digest_word;

    // Shadow copy of the hashing state
    logic [31:0]  run_hash [8];
    logic [7:0]   blk [64];
    int           blk_fill;
    logic [63:0]  msg_bits;
    t_digest_word digest_q [$];
    int           fails;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Fold the buffered block into the running hash
    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1;
        logic [31:0] t2;
        for (int i = 0; i < 16; i++) begin
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        end
        for (int i = 16; i < 64; i++) begin
            w[i] = w[i-16] + w[i-7]
                 + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
                 + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
        end
        for (int i = 0; i < 8; i++) begin
            v[i] = run_hash[i];
        end
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_ROUND[i] + w[i];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) begin
            run_hash[i] = run_hash[i] + v[i];
        end
    endtask

    task automatic restart_message();
        for (int i = 0; i < 8; i++) begin
            run_hash[i] = H_INIT[i];
        end
        blk_fill = 0;
        msg_bits = '0;
    endtask

    // Take one accepted word; on an end mark pad, finish and queue the digest
    task automatic absorb_word(input logic [7:0] data, input logic has, input logic last);
        if (has) begin
            blk[blk_fill] = data;
            msg_bits = msg_bits + 64'd8;
            blk_fill++;
            if (blk_fill == 64) begin
                compress_block();
                blk_fill = 0;
            end
        end
        if (!last) return;

        blk[blk_fill] = 8'h80;
        blk_fill++;
        // no room left for the length: flush an extra block
        if (blk_fill > 56) begin
            for (int i = blk_fill; i < 64; i++) blk[i] = 8'h00;
            compress_block();
            blk_fill = 0;
        end
        for (int i = blk_fill; i < 56; i++) blk[i] = 8'h00;
        for (int i = 0; i < 8; i++) begin
            blk[56 + i] = msg_bits[63 - 8*i -: 8];
        end
        compress_block();

        for (int i = 0; i < 4; i++) begin
            digest_q.push_back('{part: {run_hash[2*i], run_hash[2*i+1]}, last: (i == 3)});
        end
        restart_message();
    endtask

    // Watch both channels: check delivered words, then predict from accepted ones
    always @(posedge i_clk) begin : monitor
        t_digest_word exp_w;
        if (!i_rst_n) begin
            restart_message();
            digest_q.delete();
            fails = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (digest_q.size() == 0) begin
                    $display("%0t: digest word %h (last %0b) arrived with none expected",
                             $time, i_digest_part, i_part_last);
                    fails++;
                end else begin
                    exp_w = digest_q.pop_front();
                    if (i_digest_part !== exp_w.part) begin
                        $display("%0t: digest_part mismatch: expected %h, actual %h",
                                 $time, exp_w.part, i_digest_part);
                        fails++;
                    end
                    if (i_part_last !== exp_w.last) begin
                        $display("%0t: part_last mismatch: expected %0b, actual %0b",
                                 $time, exp_w.last, i_part_last);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                absorb_word(i_msg_byte, i_has_byte, i_is_last);
            end
        end
        o_fail_count <= fails;
        o_pending    <= digest_q.size();
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 200;
    localparam int RAND_WORDS     = 85;
    localparam int RAND_MSGS      = 8;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [7:0]  i_msg_byte  = 8'h00;
    logic        i_has_byte  = 1'b0;
    logic        i_is_last   = 1'b0;
    logic        i_out_ready = 1'b0;
    wire         o_in_ready;
    wire         o_out_valid;
    wire  [63:0] o_digest_part;
    wire         o_part_last;

    int fail_count;
    int pending;
    int word_count  = 0;
    int idle_cycles = 0;
    bit src_idle_en = 1'b1;
    bit snk_idle_en = 1'b1;
    bit hold_armed  = 1'b0;

    sha256_stream_hasher i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_msg_byte    (i_msg_byte),
        .i_has_byte    (i_has_byte),
        .i_is_last     (i_is_last),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_digest_part (o_digest_part),
        .o_part_last   (o_part_last)
    );

    sha256_digest_checker u_digest_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_msg_byte    (i_msg_byte),
        .i_has_byte    (i_has_byte),
        .i_is_last     (i_is_last),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_digest_part (o_digest_part),
        .i_part_last   (o_part_last),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Offer one word, with random gaps ahead of it, and hold it until accepted
    task automatic send_word(input logic [7:0] data, input logic has, input logic last);
        while (src_idle_en && $urandom_range(0, 99) < 9) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_msg_byte <= data;
        i_has_byte <= has;
        i_is_last  <= last;
        do @(posedge i_clk); while (!o_in_ready);
        if (has || last) word_count++;
    endtask

    // Send a message of random bytes with stray empty words mixed in
    task automatic send_message(input int len, input bit end_alone);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 9) == 0) send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_word(8'($urandom_range(0, 255)), 1'b1, (k == len - 1) && !end_alone);
        end
        if (len == 0 || end_alone) send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // Drive the sink: random stalls plus one long hold at the first digest once the random phase starts
    initial begin : sink
        int hold_left;
        bit held;
        hold_left = 0;
        held = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_armed && !held && o_out_valid) begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (snk_idle_en && $urandom_range(0, 99) < 9) begin
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // End the run when neither channel moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int len;
        int msgs;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty message, then a word that carries nothing
        send_word(8'h00, 1'b0, 1'b1);
        send_word(8'hA5, 1'b0, 1'b0);
        // "abc" with the end mark on its last byte
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h63, 1'b1, 1'b1);
        // Single byte messages at both extremes
        send_word(8'h00, 1'b1, 1'b1);
        send_word(8'hFF, 1'b1, 1'b1);
        // End mark on its own after bytes, ignored byte set to all ones
        send_word(8'hFF, 1'b1, 1'b0);
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'h5A, 1'b0, 1'b0);
        send_word(8'hFF, 1'b0, 1'b1);
        // Empty message right after a digest
        send_word(8'h00, 1'b0, 1'b1);

        // Random messages, mostly short, some at block and padding boundaries
        hold_armed = 1'b1;
        word_count = 0;
        msgs = 0;
        while (word_count < RAND_WORDS || msgs < RAND_MSGS) begin
            src_idle_en = !(msgs >= 4 && msgs < 8);
            snk_idle_en = src_idle_en;
            if ($urandom_range(0, 7) == 0) begin
                case ($urandom_range(0, 4))
                    0: len = 55;
                    1: len = 56;
                    2: len = 63;
                    3: len = 64;
                    default: len = 119;
                endcase
            end else begin
                len = $urandom_range(0, 9);
            end
            send_message(len, 1'($urandom_range(0, 1)));
            msgs++;
        end
        i_in_valid <= 1'b0;
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;

        // Drain outstanding digests, then watch for strays
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
